### hw/rtl/assert_macros.svh
// assertion macros used by the rtl top file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off during reset
`define GCO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check, also active during reset
`define GCO_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/gco_pkg.sv
// package with constants, types and helpers of the chain ordering block
package gco_pkg;

  localparam int DEF_MAX_COLUMNS = 16;
  localparam int FIELD_COLS      = 16;
  localparam int IDX_FW          = 4;
  localparam int CORR_W          = 16;
  localparam int MAG_W           = 15;
  localparam int CFG_W           = 5;
  localparam int ADDR_W          = 3;
  localparam int DATA_W          = 32;

  localparam logic [CFG_W-1:0] COLUMN_COUNT_RST = 5'd16;
  localparam logic             REG_COLUMN_COUNT = 1'b0;

  typedef struct packed {
    logic                     en;
    logic [IDX_FW-1:0]        row;
    logic [IDX_FW-1:0]        col;
    logic signed [CORR_W-1:0] corr;
  } wr_req_t;

  function automatic logic [MAG_W-1:0] magnitude(input logic signed [CORR_W-1:0] c);
    logic [CORR_W-1:0] neg;
    logic [MAG_W-1:0]  m;
    neg = ~c + 16'd1;
    if (!c[CORR_W-1]) begin
      m = c[MAG_W-1:0];
    end else if (neg[CORR_W-1]) begin
      m = {MAG_W{1'b1}};
    end else begin
      m = neg[MAG_W-1:0];
    end
    return m;
  endfunction

endpackage

### hw/rtl/greedy_correlation_chain_order_top.sv
// greedy chain ordering: entry load, merge rounds, column order output
// operation: a plain entry is taken while idle; a final entry starts (n-1) merge rounds,
// then n results, one per cycle when not stalled
// throughput: one entry per cycle while loading; the round scan is bound by the
// single read port of the weight memory, one weight test per cycle
// reset: synchronous active low; column count returns to 16, chains to single columns
module greedy_correlation_chain_order_top
  import gco_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [IDX_FW-1:0]        in_row_index,
  input  logic [IDX_FW-1:0]        in_col_index,
  input  logic signed [CORR_W-1:0] in_correlation,
  input  logic                     in_final_entry,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [IDX_FW-1:0]        out_column,
  output logic [IDX_FW-1:0]        out_position,
  output logic                     out_last_column,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  localparam int COLS   = (MAX_COLUMNS > FIELD_COLS) ? FIELD_COLS : MAX_COLUMNS;
  localparam int IDX_W  = $clog2(COLS);
  localparam int LINK_W = IDX_W + 1;
  localparam int CNT_W  = $clog2(COLS + 1);
  localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(COLS);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_INIT  = 4'd1;
  localparam logic [3:0] ST_ROUND = 4'd2;
  localparam logic [3:0] ST_SCAN  = 4'd3;
  localparam logic [3:0] ST_DRAIN = 4'd4;
  localparam logic [3:0] ST_PICK  = 4'd5;
  localparam logic [3:0] ST_REV   = 4'd6;
  localparam logic [3:0] ST_JOIN  = 4'd7;
  localparam logic [3:0] ST_ESET  = 4'd8;
  localparam logic [3:0] ST_EMIT  = 4'd9;

  localparam logic [1:0] T_TAIL_HEAD = 2'd0;
  localparam logic [1:0] T_HEAD_TAIL = 2'd1;
  localparam logic [1:0] T_TAIL_TAIL = 2'd2;
  localparam logic [1:0] T_HEAD_HEAD = 2'd3;

  logic [3:0]        state_r, state_nxt;
  logic [CFG_W-1:0]  ccount_r;
  logic [CNT_W-1:0]  n_r, rnd_r;
  logic [IDX_W-1:0]  i_r, j_r;
  logic [1:0]        tst_r;
  logic              pv_r;
  logic [1:0]        pt_r;
  logic [IDX_W-1:0]  pi_r, pj_r;
  logic [MAG_W-1:0]  best_r;
  logic [IDX_W-1:0]  first_r, second_r;
  logic              revf_r, revs_r;
  logic [IDX_W-1:0]  rev_h_r, rev_t_r;
  logic [LINK_W-1:0] rev_c_r;
  logic [IDX_W-1:0]  lh_r, rh_r;
  logic [LINK_W-1:0] emit_c_r;
  logic [CNT_W-1:0]  k_r;
  logic              out_valid_r;
  logic [IDX_FW-1:0] out_column_r, out_position_r;
  logic              out_last_r;

  logic [LINK_W-1:0] succ_r [COLS];
  logic [LINK_W-1:0] pred_r [COLS];
  logic [IDX_W-1:0]  tail_r [COLS];
  logic [COLS-1:0]   head_r;

  logic              in_acc, cfg_wr, out_load;
  logic [IDX_W-1:0]  h0, h1;
  logic              h0_found, h1_found;
  logic [IDX_W-1:0]  rd_a, rd_b;
  logic [MAG_W-1:0]  rd_data;
  logic [CNT_W-1:0]  n_eff;
  logic              i_last, j_last, k_last;
  wr_req_t           wr;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_COLUMN_COUNT);
  assign prdata    = (paddr[ADDR_W-1] == REG_COLUMN_COUNT) ? DATA_W'(ccount_r) : '0;
  assign out_valid = out_valid_r;
  assign out_column      = out_column_r;
  assign out_position    = out_position_r;
  assign out_last_column = out_last_r;

  assign wr.en   = in_acc;
  assign wr.row  = in_row_index;
  assign wr.col  = in_col_index;
  assign wr.corr = in_correlation;

  always_comb begin
    if (ccount_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(ccount_r) > COLS) begin
      n_eff = CNT_W'(COLS);
    end else begin
      n_eff = CNT_W'(ccount_r);
    end
  end

  // two lowest chain heads
  always_comb begin
    h0 = '0;
    h1 = '0;
    h0_found = 1'b0;
    h1_found = 1'b0;
    for (int c = 0; c < COLS; c++) begin
      if (head_r[c]) begin
        if (!h0_found) begin
          h0 = IDX_W'(c);
          h0_found = 1'b1;
        end else if (!h1_found) begin
          h1 = IDX_W'(c);
          h1_found = 1'b1;
        end
      end
    end
  end

  assign i_last = (CNT_W'(i_r) == n_r - CNT_W'(1));
  assign j_last = (CNT_W'(j_r) == n_r - CNT_W'(1));
  assign k_last = (k_r == n_r - CNT_W'(1));

  always_comb begin
    case (tst_r)
      T_TAIL_HEAD: begin
        rd_a = tail_r[i_r];
        rd_b = j_r;
      end
      T_HEAD_TAIL: begin
        rd_a = i_r;
        rd_b = tail_r[j_r];
      end
      T_TAIL_TAIL: begin
        rd_a = tail_r[i_r];
        rd_b = tail_r[j_r];
      end
      default: begin
        rd_a = i_r;
        rd_b = j_r;
      end
    endcase
  end

  gco_wmem #(.COLS(COLS), .IDX_W(IDX_W)) u_wmem (
    .clk     (clk),
    .wr      (wr),
    .rd_a    (rd_a),
    .rd_b    (rd_b),
    .rd_data (rd_data)
  );

  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc && in_final_entry) state_nxt = ST_INIT;
      ST_INIT:  state_nxt = ST_ROUND;
      ST_ROUND: state_nxt = (rnd_r >= n_r) ? ST_ESET : ST_SCAN;
      ST_SCAN:  if (tst_r == T_HEAD_HEAD && i_last && j_last) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_PICK;
      ST_PICK:  state_nxt = (revf_r || revs_r) ? ST_REV : ST_JOIN;
      ST_REV:   if (rev_c_r >= NONE_LINK) state_nxt = ST_JOIN;
      ST_JOIN:  state_nxt = ST_ROUND;
      ST_ESET:  state_nxt = ST_EMIT;
      ST_EMIT:  if (out_load && k_last) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ccount_r    <= COLUMN_COUNT_RST;
      out_valid_r <= 1'b0;
      pv_r        <= 1'b0;
      head_r      <= '1;
      for (int c = 0; c < COLS; c++) begin
        succ_r[c] <= NONE_LINK;
        pred_r[c] <= NONE_LINK;
        tail_r[c] <= IDX_W'(c);
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        ccount_r <= pwdata[CFG_W-1:0];
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      pv_r <= (state_r == ST_SCAN) && head_r[i_r] && head_r[j_r] && (i_r != j_r);

      case (state_r)
        ST_INIT: begin
          for (int c = 0; c < COLS; c++) begin
            succ_r[c] <= NONE_LINK;
            pred_r[c] <= NONE_LINK;
            tail_r[c] <= IDX_W'(c);
            head_r[c] <= (32'(c) < 32'(n_r));
          end
        end
        ST_REV: begin
          if (rev_c_r < NONE_LINK) begin
            succ_r[rev_c_r[IDX_W-1:0]] <= pred_r[rev_c_r[IDX_W-1:0]];
            pred_r[rev_c_r[IDX_W-1:0]] <= succ_r[rev_c_r[IDX_W-1:0]];
          end else begin
            head_r[rev_h_r] <= 1'b0;
            head_r[rev_t_r] <= 1'b1;
            tail_r[rev_t_r] <= rev_h_r;
          end
        end
        ST_JOIN: begin
          succ_r[tail_r[lh_r]] <= LINK_W'(rh_r);
          pred_r[rh_r]         <= LINK_W'(tail_r[lh_r]);
          head_r[rh_r]         <= 1'b0;
          tail_r[lh_r]         <= tail_r[rh_r];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    pt_r <= tst_r;
    pi_r <= i_r;
    pj_r <= j_r;
    if (pv_r && rd_data > best_r) begin
      best_r <= rd_data;
      case (pt_r)
        T_TAIL_HEAD: begin
          first_r <= pi_r; second_r <= pj_r; revf_r <= 1'b0; revs_r <= 1'b0;
        end
        T_HEAD_TAIL: begin
          first_r <= pj_r; second_r <= pi_r; revf_r <= 1'b0; revs_r <= 1'b0;
        end
        T_TAIL_TAIL: begin
          first_r <= pi_r; second_r <= pj_r; revf_r <= 1'b0; revs_r <= 1'b1;
        end
        default: begin
          first_r <= pi_r; second_r <= pj_r; revf_r <= 1'b1; revs_r <= 1'b0;
        end
      endcase
    end
    case (state_r)
      ST_IDLE: begin
        n_r <= n_eff;
      end
      ST_INIT: begin
        rnd_r <= CNT_W'(1);
      end
      ST_ROUND: begin
        best_r   <= '0;
        first_r  <= h0;
        second_r <= h1;
        revf_r   <= 1'b0;
        revs_r   <= 1'b0;
        i_r      <= '0;
        j_r      <= '0;
        tst_r    <= T_TAIL_HEAD;
      end
      ST_SCAN: begin
        tst_r <= tst_r + 2'd1;
        if (tst_r == T_HEAD_HEAD) begin
          if (j_last) begin
            j_r <= '0;
            i_r <= i_r + IDX_W'(1);
          end else begin
            j_r <= j_r + IDX_W'(1);
          end
        end
      end
      ST_PICK: begin
        rev_h_r <= revf_r ? first_r : second_r;
        rev_t_r <= revf_r ? tail_r[first_r] : tail_r[second_r];
        rev_c_r <= LINK_W'(revf_r ? first_r : second_r);
        lh_r    <= first_r;
        rh_r    <= second_r;
      end
      ST_REV: begin
        if (rev_c_r < NONE_LINK) begin
          rev_c_r <= succ_r[rev_c_r[IDX_W-1:0]];
        end else if (revf_r) begin
          lh_r <= rev_t_r;
        end else begin
          rh_r <= rev_t_r;
        end
      end
      ST_JOIN: begin
        rnd_r <= rnd_r + CNT_W'(1);
      end
      ST_ESET: begin
        emit_c_r <= LINK_W'(h0);
        k_r      <= '0;
      end
      ST_EMIT: begin
        if (out_load) begin
          out_column_r   <= IDX_FW'(emit_c_r[IDX_W-1:0]);
          out_position_r <= IDX_FW'(k_r);
          out_last_r     <= k_last;
          emit_c_r       <= succ_r[emit_c_r[IDX_W-1:0]];
          k_r            <= k_r + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

`include "assert_macros.svh"

  `GCO_ASSERT(a_best_grows, pv_r |=> (best_r >= $past(best_r)), "best weight fell during scan")
  `GCO_ASSERT(a_join_distinct, (state_r == ST_JOIN) |-> (lh_r != rh_r), "joining a chain to itself")
  `GCO_ASSERT(a_one_chain, (state_r == ST_ESET) |-> $onehot(head_r), "more than one chain left")
  `GCO_ASSERT_RST(a_reset_idle, !rst_n |=> (state_r == ST_IDLE && !out_valid_r), "not idle after reset")

endmodule

### hw/rtl/gco_wmem.sv
// correlation magnitude store, one write and one registered read per cycle
module gco_wmem
  import gco_pkg::*;
#(
  parameter int COLS  = DEF_MAX_COLUMNS,
  parameter int IDX_W = 4
) (
  input  logic             clk,
  input  wr_req_t          wr,
  input  logic [IDX_W-1:0] rd_a,
  input  logic [IDX_W-1:0] rd_b,
  output logic [MAG_W-1:0] rd_data
);

  localparam int DEPTH = 1 << (2 * IDX_W);

  logic [MAG_W-1:0] mem [DEPTH];
  logic             wr_ok;

  assign wr_ok = wr.en && (32'(wr.row) < COLS) && (32'(wr.col) < COLS);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[{wr.row[IDX_W-1:0], wr.col[IDX_W-1:0]}] <= magnitude(wr.corr);
    end
    rd_data <= mem[{rd_a, rd_b}];
  end

endmodule
